### rtl/mexp_pkg.sv
package mexp_pkg;

  // Operation codes for the shared modular unit
  typedef enum logic [1:0] {
    OP_REDUCE = 2'd0,
    OP_MUL    = 2'd1
  } mexp_op_t;

  // Control bundle from sequencer to the modular unit
  typedef struct packed {
    logic     start;
    mexp_op_t op;
  } mexp_ctl_t;

endpackage

### rtl/mexp_if.sv
interface mexp_in_if #(parameter int W = 64) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] base_value;
  logic [W-1:0] exponent;
  logic [W-1:0] modulus;
  modport source (output valid, base_value, exponent, modulus, input ready);
  modport sink (input valid, base_value, exponent, modulus, output ready);
endinterface

interface mexp_out_if #(parameter int W = 64) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] power_residue;
  logic         zero_modulus;
  modport source (output valid, power_residue, zero_modulus, input ready);
  modport sink (input valid, power_residue, zero_modulus, output ready);
endinterface

### rtl/mexp_modmul.sv
// Bit-serial modular unit: one modular doubling plus conditional add per
// cycle. OP_MUL gives a*b mod m, OP_REDUCE gives a mod m (a times 1).
module mexp_modmul #(
  parameter int W = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mexp_pkg::mexp_ctl_t  ctl,
  input  logic [W-1:0]         a,
  input  logic [W-1:0]         b,
  input  logic [W-1:0]         m,
  output logic                 done,
  output logic [W-1:0]         result
);
  import mexp_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  areg;
  logic [W-1:0]  breg;
  logic [W-1:0]  acc;
  logic [W:0]    dbl;
  logic [W:0]    dsub;
  logic [W-1:0]  dres;
  logic [W:0]    sum;
  logic [W:0]    ssub;
  logic [W-1:0]  acc_next;

  // Modular doubling then conditional modular add of b. With acc < m and
  // b < m both sums stay below 2m, so one subtract suffices. For reduce,
  // b is 1 and acc < m; 2*acc+1 < 2m holds too.
  always_comb begin
    dbl  = {acc, 1'b0};
    dsub = dbl - {1'b0, m};
    dres = dsub[W] ? acc << 1 : dsub[W-1:0];
    sum  = {1'b0, dres} + (areg[W-1] ? {1'b0, breg} : '0);
    ssub = sum - {1'b0, m};
    acc_next = ssub[W] ? sum[W-1:0] : ssub[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      cnt  <= CW'(W);
      done <= 1'b0;
      acc  <= '0;
      areg <= a;
      breg <= (ctl.op == OP_REDUCE) ? W'(1) : b;
    end else if (busy) begin
      acc  <= acc_next;
      areg <= areg << 1;
      cnt  <= cnt - 1'b1;
      done <= (cnt == CW'(1));
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign result = acc;
endmodule

### rtl/mod_exp_64.sv
// Modular exponentiation: power_residue = base_value ^ exponent mod modulus.
// Input channel in_ch carries base_value, exponent and modulus; output
// channel out_ch carries power_residue and zero_modulus.
// Right-to-left square-and-multiply on one shared bit-serial modular
// multiplier. An item costs one reduction of the base and then, for
// each exponent bit up to the highest set bit, a squaring plus a
// multiply when the bit is set.
// A modulus of 0 or 1 skips the multiplier and is answered with 0; zero sets zero_modulus.
// in_ch.ready is high only while no item is in work. The result is held
// in an output register until taken; the next item is accepted while it
// waits, and its result is held back until the register is free.
// Reset (rst, synchronous) empties the block and drops any result.
module mod_exp_64 #(
  parameter int WORD_BITS = 64
) (
  input  logic clk,
  input  logic rst,
  mexp_in_if.sink    in_ch,
  mexp_out_if.source out_ch
);
  import mexp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RED, S_MUL, S_SQR, S_DONE
  } state_t;

  state_t         state;
  logic [WORD_BITS-1:0] b, e, m, x;
  logic                 zflag;
  mexp_ctl_t            ctl;
  logic [WORD_BITS-1:0] ua, ub;
  logic                 udone;
  logic [WORD_BITS-1:0] ures;
  logic                 start_next;

  mexp_modmul #(.W(WORD_BITS)) u_mul (
    .clk(clk), .rst(rst), .ctl(ctl), .a(ua), .b(ub), .m(m),
    .done(udone), .result(ures)
  );

  assign in_ch.ready = (state == S_IDLE);

  // Operand select for the shared unit
  always_comb begin
    ua = b;
    ub = b;
    if (state == S_MUL) begin
      ua = x;
      ub = b;
    end
  end

  // Launch of the next product
  always_comb begin
    start_next = 1'b0;
    unique case (state)
      S_IDLE:  start_next = in_ch.valid && (in_ch.modulus > WORD_BITS'(1));
      S_RED:   start_next = udone && (e != '0);
      S_MUL:   start_next = udone;
      S_SQR:   start_next = udone && (e[WORD_BITS-1:1] != '0);
      default: start_next = 1'b0;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_ch.valid <= 1'b0;
      ctl.start    <= 1'b0;
      ctl.op       <= OP_REDUCE;
    end else begin
      ctl.start <= start_next;
      if (state == S_DONE && (!out_ch.valid || out_ch.ready)) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            b <= in_ch.base_value;
            e <= in_ch.exponent;
            m <= in_ch.modulus;
            x <= (in_ch.modulus <= WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
            zflag <= (in_ch.modulus == '0);
            if (in_ch.modulus <= WORD_BITS'(1)) begin
              state <= S_DONE;
            end else begin
              ctl.op    <= OP_REDUCE;
              state     <= S_RED;
            end
          end
        end
        S_RED: begin
          if (udone) begin
            b <= ures;
            if (e == '0) state <= S_DONE;
            else if (e[0]) begin
              ctl.op <= OP_MUL; state <= S_MUL;
            end else begin
              ctl.op <= OP_MUL; state <= S_SQR;
            end
          end
        end
        S_MUL: begin
          if (udone) begin
            x <= ures;
            ctl.op <= OP_MUL; state <= S_SQR;
          end
        end
        S_SQR: begin
          if (udone) begin
            b <= ures;
            e <= e >> 1;
            if (e[WORD_BITS-1:1] == '0) state <= S_DONE;
            else if (e[1]) begin
              ctl.op <= OP_MUL; state <= S_MUL;
            end else begin
              ctl.op <= OP_MUL; state <= S_SQR;
            end
          end
        end
        S_DONE: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.power_residue <= x;
            out_ch.zero_modulus  <= zflag;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
